/* design/rrip_eh_pkg.sv */
// ----------------------------------------------------------------------------
// rrip_eh_pkg
// Shared types and constants for the application-aware RRIP replacement
// block with its history of missed addresses.
// ----------------------------------------------------------------------------
package rrip_eh_pkg;

    localparam int SETS_DEF = 2048;
    localparam int WAYS_DEF = 16;
    localparam int APPS_DEF = 4;
    localparam int HIST_DEF = 128;

    localparam int SET_IN_W = 11;
    localparam int WAY_IN_W = 4;
    localparam int APP_IN_W = 2;
    localparam int ADDR_W   = 64;
    localparam int RED_W    = 4;

    // History entries examined per scan cycle.
    localparam int LANES  = 16;
    localparam int LANE_W = 4;

    localparam logic [1:0] RRPV_MAX  = 2'd3;
    localparam logic [1:0] RRPV_LONG = 2'd2;
    localparam logic [1:0] RRPV_NEAR = 2'd0;

    localparam logic MODE_VICTIM = 1'b0;
    localparam logic MODE_UPDATE = 1'b1;

    typedef struct packed {
        logic                mode;
        logic [APP_IN_W-1:0] app_id;
        logic [SET_IN_W-1:0] set_index;
        logic [WAY_IN_W-1:0] way_index;
        logic [ADDR_W-1:0]   address;
        logic                is_writeback;
        logic                is_hit;
    } item_t;

    typedef struct packed {
        logic [3:0] victim_way;
        logic       history_match;
    } result_t;

    typedef struct packed {
        logic latch;
        logic clear_wr;
        logic red_step;
        logic rd_en;
        logic scan_step;
        logic pick_step;
        logic vict_wr;
        logic hist_shift;
        logic upd_wr;
    } cmd_t;

    typedef struct packed {
        logic mode;
    } status_t;

endpackage

/* design/rrip_eh_ctrl.sv */
// ----------------------------------------------------------------------------
// rrip_eh_ctrl
// Sequencer: clearing pass, set reduction, history scan, application pick,
// victim write-back, history shift and history update.
// ----------------------------------------------------------------------------
module rrip_eh_ctrl #(
    parameter int SETS = rrip_eh_pkg::SETS_DEF,
    parameter int APPS = rrip_eh_pkg::APPS_DEF,
    parameter int HIST = rrip_eh_pkg::HIST_DEF,
    localparam int SET_W  = (SETS > 1) ? $clog2(SETS) : 1,
    localparam int APP_W  = (APPS > 1) ? $clog2(APPS) : 1,
    localparam int CHUNKS = (HIST + rrip_eh_pkg::LANES - 1) / rrip_eh_pkg::LANES,
    localparam int CHK_W  = (CHUNKS > 1) ? $clog2(CHUNKS) : 1
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  rrip_eh_pkg::status_t         status,
    output rrip_eh_pkg::cmd_t            cmd,
    output logic [SET_W-1:0]             clr_addr,
    output logic [rrip_eh_pkg::RED_W-1:0] red_shift,
    output logic [CHK_W-1:0]             scan_chunk,
    output logic [APP_W-1:0]             pick_app
);

    localparam bit POW2   = ((SETS & (SETS - 1)) == 0);
    localparam int RED_STEPS = (SETS >= 2048 || POW2) ? 0 : 12 - $clog2(SETS);

    localparam logic [2:0] S_CLEAR  = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_REDUCE = 3'd2;
    localparam logic [2:0] S_SCAN   = 3'd3;
    localparam logic [2:0] S_PICK   = 3'd4;
    localparam logic [2:0] S_VICT   = 3'd5;
    localparam logic [2:0] S_SHIFT  = 3'd6;
    localparam logic [2:0] S_UPDATE = 3'd7;

    logic [2:0]                      state_reg, state_next;
    logic [SET_W-1:0]                clr_reg, clr_next;
    logic [rrip_eh_pkg::RED_W-1:0]   red_reg, red_next;
    logic [CHK_W-1:0]                scan_reg, scan_next;
    logic [APP_W-1:0]                pick_reg, pick_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg   <= '0;
            red_reg   <= '0;
            scan_reg  <= '0;
            pick_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            red_reg   <= red_next;
            scan_reg  <= scan_next;
            pick_reg  <= pick_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        clr_next   = clr_reg;
        red_next   = red_reg;
        scan_next  = scan_reg;
        pick_next  = pick_reg;
        cmd        = '0;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clear_wr = 1'b1;
                if (clr_reg == SET_W'(SETS - 1))
                    state_next = S_IDLE;
                else
                    clr_next = clr_reg + 1'b1;
            end
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.latch = 1'b1;
                    scan_next = '0;
                    if (RED_STEPS > 0)
                    begin
                        red_next   = rrip_eh_pkg::RED_W'(RED_STEPS - 1);
                        state_next = S_REDUCE;
                    end
                    else
                        state_next = S_SCAN;
                end
            end
            S_REDUCE:
            begin
                cmd.red_step = 1'b1;
                if (red_reg == '0)
                    state_next = S_SCAN;
                else
                    red_next = red_reg - 1'b1;
            end
            S_SCAN:
            begin
                cmd.scan_step = 1'b1;
                cmd.rd_en     = (scan_reg == '0);
                if (scan_reg == CHK_W'(CHUNKS - 1))
                begin
                    pick_next  = '0;
                    state_next = (status.mode == rrip_eh_pkg::MODE_VICTIM) ? S_PICK : S_UPDATE;
                end
                else
                    scan_next = scan_reg + 1'b1;
            end
            S_PICK:
            begin
                cmd.pick_step = 1'b1;
                if (pick_reg == APP_W'(APPS - 1))
                    state_next = S_VICT;
                else
                    pick_next = pick_reg + 1'b1;
            end
            S_VICT:
            begin
                cmd.vict_wr = 1'b1;
                state_next  = S_SHIFT;
            end
            S_SHIFT:
            begin
                cmd.hist_shift = 1'b1;
                state_next     = S_IDLE;
            end
            S_UPDATE:
            begin
                cmd.upd_wr = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy       = (state_reg != S_IDLE);
    assign clr_addr   = clr_reg;
    assign red_shift  = red_reg;
    assign scan_chunk = scan_reg;
    assign pick_app   = pick_reg;

endmodule

/* design/rrip_eh_dp.sv */
// ----------------------------------------------------------------------------
// rrip_eh_dp
// Datapath: per-set line memory, history shift line with its lane scanner,
// application pick, victim ageing and result register.
// ----------------------------------------------------------------------------
module rrip_eh_dp #(
    parameter int SETS = rrip_eh_pkg::SETS_DEF,
    parameter int WAYS = rrip_eh_pkg::WAYS_DEF,
    parameter int APPS = rrip_eh_pkg::APPS_DEF,
    parameter int HIST = rrip_eh_pkg::HIST_DEF,
    localparam int SET_W  = (SETS > 1) ? $clog2(SETS) : 1,
    localparam int APP_W  = (APPS > 1) ? $clog2(APPS) : 1,
    localparam int CHUNKS = (HIST + rrip_eh_pkg::LANES - 1) / rrip_eh_pkg::LANES,
    localparam int CHK_W  = (CHUNKS > 1) ? $clog2(CHUNKS) : 1
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  rrip_eh_pkg::cmd_t             cmd,
    output rrip_eh_pkg::status_t          status,
    input  rrip_eh_pkg::item_t            item,
    input  logic [SET_W-1:0]              clr_addr,
    input  logic [rrip_eh_pkg::RED_W-1:0] red_shift,
    input  logic [CHK_W-1:0]              scan_chunk,
    input  logic [APP_W-1:0]              pick_app,
    output rrip_eh_pkg::result_t          result,
    output logic                          done
);

    localparam int AW     = (APP_W > 2) ? APP_W : 2;
    localparam int WAY_W  = $clog2(WAYS);
    localparam int ROW_W  = WAYS * 4;
    localparam int IDX_W  = $clog2(HIST);
    localparam int HIST_W = $clog2(HIST + 1);
    localparam int FULL_W = CHK_W + rrip_eh_pkg::LANE_W + 1;
    localparam bit POW2   = ((SETS & (SETS - 1)) == 0);
    localparam logic [10:0] SET_MASK = (SETS >= 2048 || !POW2) ? 11'h7FF
                                                               : 11'(SETS - 1);
    localparam logic [11:0] SETS_12  = 12'(SETS % 4096);
    localparam logic [ROW_W-1:0] CLR_ROW = {WAYS{4'b0011}};

    // Line memory: one row per set, four bits per way (owner above rrpv).
    logic [ROW_W-1:0] line_mem [SETS];
    logic [ROW_W-1:0] mem_q;

    logic [1:0]               hist_app_reg  [HIST];
    logic [10:0]              hist_set_reg  [HIST];
    logic [63:0]              hist_addr_reg [HIST];

    rrip_eh_pkg::item_t       item_reg;
    logic [10:0]              rem_reg;
    logic                     match_reg;
    logic [HIST_W-1:0]        cnt_reg [APPS];
    logic [HIST_W-1:0]        pos_reg [APPS];
    logic [HIST_W-1:0]        best_reg;
    logic [APP_W-1:0]         chosen_reg;
    logic [APP_W-1:0]         rr_reg;
    logic [WAY_W-1:0]         victim_reg;
    logic [IDX_W-1:0]         drop_reg;
    rrip_eh_pkg::result_t     result_reg, result_next;
    logic                     done_reg;

    logic [SET_W-1:0]         set_addr;
    logic [11:0]              red_sub;

    // Scan lanes.
    logic [FULL_W-1:0]        lane_full [rrip_eh_pkg::LANES];
    logic [IDX_W-1:0]         lane_idx  [rrip_eh_pkg::LANES];
    logic [rrip_eh_pkg::LANES-1:0] lane_ok;
    logic                     chunk_match;
    logic [rrip_eh_pkg::LANE_W:0] chunk_cnt [APPS];
    logic                     chunk_found [APPS];
    logic [FULL_W-1:0]        chunk_first [APPS];

    // Application pick.
    logic [HIST_W-1:0]        pick_cnt, pick_pos;
    logic [HIST_W:0]          pick_gain;
    logic [HIST_W-1:0]        drop_pos;

    // Victim and update rows.
    logic [1:0]               way_rrpv [WAYS];
    logic [WAYS-1:0]          own, at3, grp;
    logic                     age;
    logic [1:0]               age_k;
    logic [ROW_W-1:0]         vict_row, upd_row, wr_row;
    logic [WAY_W-1:0]         vict_way;
    logic                     way_ok;
    logic                     mem_we;
    logic [SET_W-1:0]         mem_waddr;

    assign set_addr = SET_W'(rem_reg);
    assign red_sub  = SETS_12 << red_shift;
    assign status.mode = item_reg.mode;

    always_comb
    begin
        chunk_match = 1'b0;
        for (int j = 0; j < rrip_eh_pkg::LANES; j++)
        begin
            lane_full[j] = {1'b0, scan_chunk, rrip_eh_pkg::LANE_W'(j)};
            lane_ok[j]   = (lane_full[j] < FULL_W'(HIST));
            lane_idx[j]  = lane_ok[j] ? IDX_W'(lane_full[j]) : '0;
            if (lane_ok[j] && hist_set_reg[lane_idx[j]] == rem_reg &&
                hist_addr_reg[lane_idx[j]] == item_reg.address)
                chunk_match = 1'b1;
        end
        for (int a = 0; a < APPS; a++)
        begin
            chunk_cnt[a]   = '0;
            chunk_found[a] = 1'b0;
            chunk_first[a] = '0;
            for (int j = rrip_eh_pkg::LANES - 1; j >= 0; j--)
            begin
                if (lane_ok[j] && AW'(hist_app_reg[lane_idx[j]]) == AW'(a))
                begin
                    chunk_cnt[a]   = chunk_cnt[a] + 1'b1;
                    chunk_found[a] = 1'b1;
                    chunk_first[a] = lane_full[j];
                end
            end
        end
    end

    always_comb
    begin
        pick_cnt  = cnt_reg[pick_app];
        pick_pos  = pos_reg[pick_app];
        pick_gain = {1'b0, pick_cnt} - {1'b0, pick_pos};
        drop_pos  = pos_reg[chosen_reg];
    end

    always_comb
    begin
        for (int w = 0; w < WAYS; w++)
        begin
            way_rrpv[w] = mem_q[w*4 +: 2];
            own[w]      = (mem_q[w*4+2 +: 2] == item_reg.app_id);
            at3[w]      = (way_rrpv[w] == rrip_eh_pkg::RRPV_MAX);
        end
        // With no line at the maximum, the ageing group is the requester's
        // lines if it has any, and the step is what lifts its oldest to 3.
        age   = ~|at3;
        grp   = (|own) ? own : '1;
        age_k = 2'd3;
        for (int w = 0; w < WAYS; w++)
        begin
            if (grp[w] && (2'd3 - way_rrpv[w]) < age_k)
                age_k = 2'd3 - way_rrpv[w];
        end
        vict_row = mem_q;
        for (int w = 0; w < WAYS; w++)
        begin
            if (age && grp[w])
                vict_row[w*4 +: 2] = way_rrpv[w] + age_k;
        end
        vict_way = '0;
        for (int w = WAYS - 1; w >= 0; w--)
        begin
            if (vict_row[w*4 +: 2] == rrip_eh_pkg::RRPV_MAX)
                vict_way = WAY_W'(w);
        end
        if (|(own & at3))
        begin
            for (int w = WAYS - 1; w >= 0; w--)
            begin
                if (own[w] && at3[w])
                    vict_way = WAY_W'(w);
            end
        end
    end

    always_comb
    begin
        way_ok  = ({1'b0, item_reg.way_index} < 5'(WAYS % 32)) || (WAYS == 32);
        upd_row = mem_q;
        for (int w = 0; w < WAYS; w++)
        begin
            if (WAY_W'(item_reg.way_index) == WAY_W'(w))
            begin
                if (item_reg.is_writeback)
                    upd_row[w*4 +: 2] = rrip_eh_pkg::RRPV_LONG;
                else if (item_reg.is_hit)
                    upd_row[w*4 +: 2] = rrip_eh_pkg::RRPV_NEAR;
                else
                begin
                    upd_row[w*4 +: 2]   = match_reg ? rrip_eh_pkg::RRPV_NEAR
                                                    : rrip_eh_pkg::RRPV_LONG;
                    upd_row[w*4+2 +: 2] = item_reg.app_id;
                end
            end
        end
        mem_we    = cmd.clear_wr || cmd.vict_wr || (cmd.upd_wr && way_ok);
        mem_waddr = cmd.clear_wr ? clr_addr : set_addr;
        wr_row    = cmd.clear_wr ? CLR_ROW : (cmd.vict_wr ? vict_row : upd_row);
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            line_mem[mem_waddr] <= wr_row;
        if (cmd.rd_en)
            mem_q <= line_mem[set_addr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            item_reg   <= item;
            rem_reg    <= item.set_index & SET_MASK;
            match_reg  <= 1'b0;
            best_reg   <= '0;
            chosen_reg <= rr_reg;
            for (int a = 0; a < APPS; a++)
            begin
                cnt_reg[a] <= '0;
                pos_reg[a] <= HIST_W'(HIST);
            end
        end
        if (cmd.red_step && {1'b0, rem_reg} >= red_sub)
            rem_reg <= rem_reg - red_sub[10:0];
        if (cmd.scan_step)
        begin
            if (chunk_match)
                match_reg <= 1'b1;
            for (int a = 0; a < APPS; a++)
            begin
                cnt_reg[a] <= cnt_reg[a] + HIST_W'(chunk_cnt[a]);
                if (chunk_found[a] && pos_reg[a] == HIST_W'(HIST))
                    pos_reg[a] <= HIST_W'(chunk_first[a]);
            end
        end
        if (cmd.pick_step && pick_cnt > pick_pos && pick_gain[HIST_W-1:0] > best_reg)
        begin
            best_reg   <= pick_gain[HIST_W-1:0];
            chosen_reg <= pick_app;
        end
        if (cmd.vict_wr)
        begin
            victim_reg <= vict_way;
            // A winner without entries gives up the oldest entry instead.
            drop_reg   <= (drop_pos == HIST_W'(HIST)) ? '0 : IDX_W'(drop_pos);
        end
        result_reg <= result_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < HIST; i++)
            begin
                hist_app_reg[i]  <= '0;
                hist_set_reg[i]  <= '0;
                hist_addr_reg[i] <= '0;
            end
            rr_reg   <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.hist_shift || cmd.upd_wr;
            if (cmd.hist_shift)
            begin
                rr_reg <= (rr_reg == APP_W'(APPS - 1)) ? '0 : rr_reg + 1'b1;
                for (int i = 0; i < HIST - 1; i++)
                begin
                    if (IDX_W'(i) >= drop_reg)
                    begin
                        hist_app_reg[i]  <= hist_app_reg[i+1];
                        hist_set_reg[i]  <= hist_set_reg[i+1];
                        hist_addr_reg[i] <= hist_addr_reg[i+1];
                    end
                end
                hist_app_reg[HIST-1]  <= item_reg.app_id;
                hist_set_reg[HIST-1]  <= rem_reg;
                hist_addr_reg[HIST-1] <= item_reg.address;
            end
        end
    end

    always_comb
    begin
        result_next = '0;
        if (cmd.hist_shift)
            result_next.victim_way = 4'(victim_reg);
        if (cmd.upd_wr)
            result_next.history_match = match_reg && !item_reg.is_writeback &&
                                        !item_reg.is_hit;
    end

    assign result = result_reg;
    assign done   = done_reg;

endmodule

/* design/app_aware_rrip_with_eviction_history.sv */
// A victim word runs set reduction, history scan, application pick, victim
// write and history shift before its result, an update word set reduction,
// history scan and update write; the scan walks CHUNKS chunks, the history
// depth over 16 scan lanes. The next word is taken in the cycle its result
// is shown. Only SETS that are not powers of two below 2048 use set reduction.
// After reset the line memory is cleared one set a cycle, with busy high.
// ----------------------------------------------------------------------------
// app_aware_rrip_with_eviction_history
// Application-aware RRIP victim selection and update, with a FIFO history
// of missed addresses steering the insertion value of fills.
// ----------------------------------------------------------------------------
module app_aware_rrip_with_eviction_history #(
    parameter int SETS = rrip_eh_pkg::SETS_DEF,
    parameter int WAYS = rrip_eh_pkg::WAYS_DEF,
    parameter int APPS = rrip_eh_pkg::APPS_DEF,
    parameter int HIST = rrip_eh_pkg::HIST_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  rrip_eh_pkg::item_t   item,
    output rrip_eh_pkg::result_t result,
    output logic                 done
);

    localparam int SET_W  = (SETS > 1) ? $clog2(SETS) : 1;
    localparam int APP_W  = (APPS > 1) ? $clog2(APPS) : 1;
    localparam int CHUNKS = (HIST + rrip_eh_pkg::LANES - 1) / rrip_eh_pkg::LANES;
    localparam int CHK_W  = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;

    rrip_eh_pkg::cmd_t             cmd;
    rrip_eh_pkg::status_t          status;
    logic [SET_W-1:0]              clr_addr;
    logic [rrip_eh_pkg::RED_W-1:0] red_shift;
    logic [CHK_W-1:0]              scan_chunk;
    logic [APP_W-1:0]              pick_app;

    rrip_eh_ctrl #(
        .SETS (SETS),
        .APPS (APPS),
        .HIST (HIST)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .status     (status),
        .cmd        (cmd),
        .clr_addr   (clr_addr),
        .red_shift  (red_shift),
        .scan_chunk (scan_chunk),
        .pick_app   (pick_app)
    );

    rrip_eh_dp #(
        .SETS (SETS),
        .WAYS (WAYS),
        .APPS (APPS),
        .HIST (HIST)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .item       (item),
        .clr_addr   (clr_addr),
        .red_shift  (red_shift),
        .scan_chunk (scan_chunk),
        .pick_app   (pick_app),
        .result     (result),
        .done       (done)
    );

endmodule
